// ----- rtl/vfve_pkg.sv -----
package vfve_pkg;

    localparam int NUM_FACES = 6;
    localparam int FACE_W    = 3;
    localparam int STEP_W    = 3;
    localparam int MASK_W    = 6;

    localparam logic [STEP_W-1:0] TRI_LAST_STEP  = 3'd5;
    localparam logic [STEP_W-1:0] QUAD_LAST_STEP = 3'd3;

    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;

    typedef struct packed {
        logic [7:0]        pos_x;
        logic [7:0]        pos_y;
        logic [7:0]        pos_z;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } voxel_t;

    typedef struct packed {
        logic              load;
        logic              emit;
        logic [FACE_W-1:0] face;
        logic [STEP_W-1:0] step;
        logic              quad;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic              out_free;
    } stat_t;

    // Corner of the face visited at a given step of the emit sequence.
    function automatic logic [1:0] corner_of_step(logic [STEP_W-1:0] step, logic quad);
        logic [1:0] corner;
        corner = 2'd0;
        if (quad)
        begin
            case (step)
                3'd0:    corner = 2'd0;
                3'd1:    corner = 2'd2;
                3'd2:    corner = 2'd3;
                3'd3:    corner = 2'd1;
                default: corner = 2'd0;
            endcase
        end
        else
        begin
            case (step)
                3'd0:    corner = 2'd0;
                3'd1:    corner = 2'd2;
                3'd2:    corner = 2'd1;
                3'd3:    corner = 2'd1;
                3'd4:    corner = 2'd2;
                3'd5:    corner = 2'd3;
                default: corner = 2'd0;
            endcase
        end
        return corner;
    endfunction

    // Sign bits of a corner: bit 2 is x, bit 1 is y, bit 0 is z; a set bit means plus one.
    function automatic logic [2:0] corner_sign(logic [FACE_W-1:0] face, logic [1:0] corner);
        logic [11:0] row;
        row = 12'd0;
        case (face)
            FACE_NEG_X: row = {3'd2, 3'd3, 3'd0, 3'd1};
            FACE_POS_X: row = {3'd7, 3'd6, 3'd5, 3'd4};
            FACE_NEG_Y: row = {3'd4, 3'd0, 3'd5, 3'd1};
            FACE_POS_Y: row = {3'd7, 3'd3, 3'd6, 3'd2};
            FACE_NEG_Z: row = {3'd6, 3'd2, 3'd4, 3'd0};
            FACE_POS_Z: row = {3'd3, 3'd7, 3'd1, 3'd5};
            default:    row = 12'd0;
        endcase
        return row[corner*3 +: 3];
    endfunction

    function automatic logic [7:0] shift_coord(logic [7:0] p, logic plus);
        return plus ? p + 8'd1 : p - 8'd1;
    endfunction

endpackage

// ----- rtl/vfve_ifs.sv -----
interface vfve_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] pos_z;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] face_mask;

    modport source (
        output valid, pos_x, pos_y, pos_z, red, green, blue, face_mask,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, red, green, blue, face_mask,
        output ready
    );
endinterface

interface vfve_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] vertex_x;
    logic [7:0] vertex_y;
    logic [7:0] vertex_z;
    logic [7:0] vertex_red;
    logic [7:0] vertex_green;
    logic [7:0] vertex_blue;
    logic       last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, vertex_z, vertex_red, vertex_green,
               vertex_blue, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, vertex_z, vertex_red, vertex_green,
               vertex_blue, last_vertex,
        output ready
    );
endinterface

// ----- rtl/vfve_ctrl.sv -----
module vfve_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [vfve_pkg::MASK_W-1:0]   in_face_mask,
    input  logic                          cfg_we,
    input  logic                          cfg_data,
    input  vfve_pkg::stat_t               stat,
    output logic                          in_ready,
    output logic                          busy,
    output vfve_pkg::cmd_t                cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                          state_reg, state_next;
    logic [vfve_pkg::MASK_W-1:0]   mask_reg, mask_next;
    logic [vfve_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          quad_reg;

    logic [vfve_pkg::FACE_W-1:0]   face;
    logic [vfve_pkg::MASK_W-1:0]   face_bit;
    logic [vfve_pkg::MASK_W-1:0]   mask_rest;
    logic [vfve_pkg::STEP_W-1:0]   last_step;
    logic                          accept;
    logic                          emit;
    logic                          face_done;

    // The highest set mask bit is the next face to emit.
    always_comb
    begin
        face     = '0;
        face_bit = '0;
        for (int i = 0; i < vfve_pkg::MASK_W; i++)
        begin
            if (mask_reg[i])
            begin
                face     = vfve_pkg::FACE_W'(vfve_pkg::NUM_FACES - 1 - i);
                face_bit = vfve_pkg::MASK_W'(1) << i;
            end
        end
    end

    assign mask_rest = mask_reg & ~face_bit;
    assign last_step = quad_reg ? vfve_pkg::QUAD_LAST_STEP : vfve_pkg::TRI_LAST_STEP;
    assign in_ready  = (state_reg == ST_IDLE);
    assign busy      = (state_reg == ST_EMIT);
    assign accept    = in_valid && in_ready;
    assign emit      = (state_reg == ST_EMIT) && stat.out_free;
    assign face_done = (step_reg == last_step);

    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_face_mask != '0))
                begin
                    state_next = ST_EMIT;
                    mask_next  = in_face_mask;
                    step_next  = '0;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    if (face_done)
                    begin
                        step_next = '0;
                        mask_next = mask_rest;
                        if (mask_rest == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mask_reg  <= '0;
            step_reg  <= '0;
            quad_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                quad_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        cmd.load = accept;
        cmd.emit = emit;
        cmd.face = face;
        cmd.step = step_reg;
        cmd.quad = quad_reg;
        cmd.last = face_done && (mask_rest == '0);
    end

endmodule

// ----- rtl/vfve_dp.sv -----
module vfve_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  vfve_pkg::voxel_t   voxel,
    input  vfve_pkg::cmd_t     cmd,
    output vfve_pkg::stat_t    stat,
    vfve_out_if.source         out_ch
);

    vfve_pkg::voxel_t voxel_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       vx_reg, vy_reg, vz_reg;
    logic [7:0]       vr_reg, vg_reg, vb_reg;
    logic             last_reg;
    logic [2:0]       sign;

    assign sign           = vfve_pkg::corner_sign(cmd.face,
                                vfve_pkg::corner_of_step(cmd.step, cmd.quad));
    assign stat.out_free  = !out_valid_reg || out_ch.ready;
    assign out_valid_next = cmd.emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            voxel_reg <= voxel;
        end
        if (cmd.emit)
        begin
            vx_reg   <= vfve_pkg::shift_coord(voxel_reg.pos_x, sign[2]);
            vy_reg   <= vfve_pkg::shift_coord(voxel_reg.pos_y, sign[1]);
            vz_reg   <= vfve_pkg::shift_coord(voxel_reg.pos_z, sign[0]);
            vr_reg   <= voxel_reg.red;
            vg_reg   <= voxel_reg.green;
            vb_reg   <= voxel_reg.blue;
            last_reg <= cmd.last;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.vertex_x     = vx_reg;
    assign out_ch.vertex_y     = vy_reg;
    assign out_ch.vertex_z     = vz_reg;
    assign out_ch.vertex_red   = vr_reg;
    assign out_ch.vertex_green = vg_reg;
    assign out_ch.vertex_blue  = vb_reg;
    assign out_ch.last_vertex  = last_reg;

endmodule

// ----- rtl/voxel_face_vertex_emitter.sv -----
// Channel   Direction  Word
// in_ch     sink       pos_x, pos_y, pos_z, red, green, blue, face_mask
// out_ch    source     vertex_x, vertex_y, vertex_z, vertex_red, vertex_green,
//                      vertex_blue, last_vertex
// cfg       write      cfg_we, cfg_data (quad_mode)
//
// A voxel is accepted and then gives four or six vertices per visible face, up to 36
// in all, one at a time through the single output register.
// A voxel with an empty mask is taken and gives no word.
// Reset clears the controller, the output valid flag and quad_mode.
// A stalled output holds the controller; a new voxel is taken once the last
// vertex of the previous one sits in the output register.
module voxel_face_vertex_emitter (
    input  logic        clk,
    input  logic        rst_n,
    vfve_in_if.sink     in_ch,
    vfve_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic        cfg_data
);

    vfve_pkg::voxel_t voxel;
    vfve_pkg::cmd_t   cmd;
    vfve_pkg::stat_t  stat;
    logic             in_ready;
    logic             busy;

    assign voxel.pos_x = in_ch.pos_x;
    assign voxel.pos_y = in_ch.pos_y;
    assign voxel.pos_z = in_ch.pos_z;
    assign voxel.red   = in_ch.red;
    assign voxel.green = in_ch.green;
    assign voxel.blue  = in_ch.blue;
    assign in_ch.ready = in_ready;

    vfve_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_face_mask (in_ch.face_mask),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .in_ready     (in_ready),
        .busy         (busy),
        .cmd          (cmd)
    );

    vfve_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .voxel  (voxel),
        .cmd    (cmd),
        .stat   (stat),
        .out_ch (out_ch)
    );

    a_empty_mask_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.face_mask == 6'd0)) |=> !busy)
        else $error("empty mask started an emit sequence");

    a_last_ends_voxel: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> !busy)
        else $error("controller still busy after the last vertex");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("vertex emitted into a full output register");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_ch.valid && (out_ch.last_vertex == $past(cmd.last))))
        else $error("emitted vertex missing from the output register");

endmodule

// ----- test/voxel_face_vertex_emitter_tb.sv -----
module voxel_face_vertex_emitter_tb;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } vertex_t;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED   = 40;
    localparam int TIMEOUT_UNITS = 8_000_000;

    // Corner visiting order within one face, first corner in the top bits.
    localparam logic [11:0] TRI_CORNER_SEQ  = {2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd3};
    localparam logic [7:0]  QUAD_CORNER_SEQ = {2'd0, 2'd2, 2'd3, 2'd1};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    vfve_in_if  in_ch ();
    vfve_out_if out_ch ();

    voxel_face_vertex_emitter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    vertex_t pending_vertices[$];
    logic    quad_mode;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      mismatch_count;
    int      tri_voxels;
    int      quad_voxels;
    int      vertices_seen;
    int      wrap_vertices;

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [2:0] face_corner_signs(logic [vfve_pkg::FACE_W-1:0] face,
                                                     logic [1:0] corner);
        logic [11:0] row;
        case (face)
            vfve_pkg::FACE_NEG_X: row = {3'd1, 3'd0, 3'd3, 3'd2};
            vfve_pkg::FACE_POS_X: row = {3'd4, 3'd5, 3'd6, 3'd7};
            vfve_pkg::FACE_NEG_Y: row = {3'd1, 3'd5, 3'd0, 3'd4};
            vfve_pkg::FACE_POS_Y: row = {3'd2, 3'd6, 3'd3, 3'd7};
            vfve_pkg::FACE_NEG_Z: row = {3'd0, 3'd4, 3'd2, 3'd6};
            default:              row = {3'd5, 3'd1, 3'd7, 3'd3};
        endcase
        return row[11 - 3 * corner -: 3];
    endfunction

    function automatic logic [7:0] step_coord(logic [7:0] p, logic up);
        return up ? p + 8'd1 : p + 8'd255;
    endfunction

    task automatic expand_voxel_faces(input vfve_pkg::voxel_t vox, input logic [5:0] mask);
        vertex_t    vtx;
        int         per_face;
        int         total;
        int         n;
        logic [1:0] corner;
        logic [2:0] sign;
        per_face = quad_mode ? 4 : 6;
        total = $countones(mask) * per_face;
        n = 0;
        for (int f = 0; f < vfve_pkg::NUM_FACES; f++)
        begin
            if (mask[5 - f])
            begin
                for (int k = 0; k < per_face; k++)
                begin
                    if (quad_mode)
                        corner = QUAD_CORNER_SEQ[7 - 2 * k -: 2];
                    else
                        corner = TRI_CORNER_SEQ[11 - 2 * k -: 2];
                    sign = face_corner_signs(vfve_pkg::FACE_W'(f), corner);
                    vtx.x     = step_coord(vox.pos_x, sign[2]);
                    vtx.y     = step_coord(vox.pos_y, sign[1]);
                    vtx.z     = step_coord(vox.pos_z, sign[0]);
                    vtx.red   = vox.red;
                    vtx.green = vox.green;
                    vtx.blue  = vox.blue;
                    vtx.last  = (n == total - 1);
                    pending_vertices.push_back(vtx);
                    n++;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            vertices_seen++;
            if (pending_vertices.size() == 0)
            begin
                report_mismatch("unexpected vertex_x", out_ch.vertex_x, 8'd0);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (want.x == 8'd0 || want.x == 8'd255 || want.y == 8'd0 || want.y == 8'd255
                    || want.z == 8'd0 || want.z == 8'd255)
                    wrap_vertices++;
                if (out_ch.vertex_x !== want.x)
                    report_mismatch("vertex_x", out_ch.vertex_x, want.x);
                if (out_ch.vertex_y !== want.y)
                    report_mismatch("vertex_y", out_ch.vertex_y, want.y);
                if (out_ch.vertex_z !== want.z)
                    report_mismatch("vertex_z", out_ch.vertex_z, want.z);
                if (out_ch.vertex_red !== want.red)
                    report_mismatch("vertex_red", out_ch.vertex_red, want.red);
                if (out_ch.vertex_green !== want.green)
                    report_mismatch("vertex_green", out_ch.vertex_green, want.green);
                if (out_ch.vertex_blue !== want.blue)
                    report_mismatch("vertex_blue", out_ch.vertex_blue, want.blue);
                if (out_ch.last_vertex !== want.last)
                    report_mismatch("last_vertex", 8'(out_ch.last_vertex), 8'(want.last));
            end
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_voxel(input vfve_pkg::voxel_t vox, input logic [5:0] mask);
        int gap;
        @(negedge clk);
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 6);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.pos_x     = vox.pos_x;
        in_ch.pos_y     = vox.pos_y;
        in_ch.pos_z     = vox.pos_z;
        in_ch.red       = vox.red;
        in_ch.green     = vox.green;
        in_ch.blue      = vox.blue;
        in_ch.face_mask = mask;
        in_ch.valid     = 1'b1;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        expand_voxel_faces(vox, mask);
        if (quad_mode)
            quad_voxels++;
        else
            tri_voxels++;
    endtask

    // An empty mask gives no word, so the task also waits out SETTLE_CYCLES after the last vertex.
    task automatic wait_for_vertices();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_quad_mode(input logic mode);
        wait_for_vertices();
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = mode;
        @(negedge clk);
        cfg_we   = 1'b0;
        quad_mode = mode;
    endtask

    function automatic vfve_pkg::voxel_t make_voxel(logic [7:0] x, logic [7:0] y,
                                                    logic [7:0] z, logic [7:0] r,
                                                    logic [7:0] g, logic [7:0] b);
        vfve_pkg::voxel_t vox;
        vox.pos_x = x;
        vox.pos_y = y;
        vox.pos_z = z;
        vox.red   = r;
        vox.green = g;
        vox.blue  = b;
        return vox;
    endfunction

    function automatic logic [7:0] random_coord();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return ($urandom_range(1) == 0) ? 8'd1 : 8'd254;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [5:0] random_mask();
        int pick;
        pick = $urandom_range(19);
        if (pick < 2)
            return 6'h00;
        else if (pick < 5)
            return 6'h01 << $urandom_range(5);
        else if (pick < 8)
            return 6'h3f;
        else
            return 6'($urandom_range(63));
    endfunction

    task automatic test_reset_triangles();
        for (int f = 0; f < vfve_pkg::NUM_FACES; f++)
            send_voxel(make_voxel(8'(16 * f + 3), 8'(200 - f), 8'(90 + 7 * f),
                                  8'h12, 8'hab, 8'hf0), 6'h20 >> f);
        send_voxel(make_voxel(8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00), 6'h3f);
        send_voxel(make_voxel(8'd255, 8'd255, 8'd255, 8'hff, 8'hff, 8'hff), 6'h3f);
        send_voxel(make_voxel(8'd5, 8'd6, 8'd7, 8'h55, 8'h66, 8'h77), 6'h00);
        send_voxel(make_voxel(8'd0, 8'd255, 8'd128, 8'haa, 8'h55, 8'h01), 6'h2a);
        send_voxel(make_voxel(8'd255, 8'd0, 8'd127, 8'h80, 8'h7f, 8'hfe), 6'h15);
    endtask

    task automatic test_quad_directed();
        write_quad_mode(1'b1);
        recv_stall_pct = 27;
        for (int f = 0; f < vfve_pkg::NUM_FACES; f++)
            send_voxel(make_voxel((f % 2 == 0) ? 8'd0 : 8'd255, 8'(37 * f), 8'(255 - 11 * f),
                                  8'(f), 8'(255 - f), 8'h3c), 6'h01 << f);
        send_voxel(make_voxel(8'd255, 8'd255, 8'd255, 8'h00, 8'hff, 8'h00), 6'h3f);
        send_voxel(make_voxel(8'd1, 8'd254, 8'd9, 8'h10, 8'h20, 8'h30), 6'h00);
        send_voxel(make_voxel(8'd0, 8'd0, 8'd0, 8'hff, 8'h00, 8'hff), 6'h3f);
        recv_stall_pct = 0;
    endtask

    task automatic test_random_phase(input logic mode, input int send_pct, input int stall_pct,
                                     input int count, input bit pause_midway);
        write_quad_mode(mode);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_for_vertices();
            send_voxel(make_voxel(random_coord(), random_coord(), random_coord(),
                                  8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255))), random_mask());
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.pos_x     = 8'd0;
        in_ch.pos_y     = 8'd0;
        in_ch.pos_z     = 8'd0;
        in_ch.red       = 8'd0;
        in_ch.green     = 8'd0;
        in_ch.blue      = 8'd0;
        in_ch.face_mask = 6'd0;
        quad_mode       = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mismatch_count  = 0;
        tri_voxels      = 0;
        quad_voxels     = 0;
        vertices_seen   = 0;
        wrap_vertices   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_triangles();
        test_quad_directed();
        test_random_phase(1'b0, 0, 0, 50, 1'b0);
        test_random_phase(1'b1, 65, 0, 50, 1'b0);
        test_random_phase(1'b0, 0, 65, 50, 1'b1);
        test_random_phase(1'b1, 27, 27, 50, 1'b0);
        test_random_phase(1'b0, 27, 27, 50, 1'b0);
        test_random_phase(1'b1, 0, 0, 50, 1'b0);
        wait_for_vertices();

        $display("Sent %0d voxels in triangle mode and %0d in quad mode, %0d vertices checked.",
                 tri_voxels, quad_voxels, vertices_seen);
        $display("Idle and stall mixes were varied per phase; %0d vertices sat on a byte edge.",
                 wrap_vertices);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("Timeout with %0d vertices outstanding.", pending_vertices.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/vfve_pkg.sv
rtl/vfve_ifs.sv
rtl/vfve_ctrl.sv
rtl/vfve_dp.sv
rtl/voxel_face_vertex_emitter.sv
test/voxel_face_vertex_emitter_tb.sv
